// ===== rtl/swpr_pkg.sv =====
// Shared types and constants for the sliding window pulse rate meter.
// Used by every module under rtl/.
package swpr_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 256;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam logic [15:0] PROC_PERIOD_RST = 16'd160;
    localparam logic [19:0] SLOT_PERIOD_RST = 20'd6000;
    localparam logic [15:0] KALPHA_RST      = 16'd13576;

    // 60000 ms per minute times 2^8 fraction scaling.
    localparam logic [23:0] CPM_SCALE = 24'd15360000;
    localparam logic [55:0] MAX56     = {56{1'b1}};

    localparam logic [1:0] REG_PROC_PERIOD = 2'd0;
    localparam logic [1:0] REG_SLOT_PERIOD = 2'd1;
    localparam logic [1:0] REG_KALPHA      = 2'd2;

    typedef struct packed {
        logic        processed;
        logic [31:0] count;
        logic [31:0] itime;
        logic [15:0] kalpha;
    } t_job;

endpackage

// ===== rtl/swpr_fifo.sv =====
// Small job queue between the front and the back of the pulse rate meter.
// Depends on swpr_pkg for the job type.
module swpr_fifo #(
    parameter int unsigned DEPTH = swpr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  swpr_pkg::t_job   i_job,
    input  logic             i_pop,
    output swpr_pkg::t_job   o_job,
    output logic             o_full,
    output logic             o_empty
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    swpr_pkg::t_job   r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [PW:0]      r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// ===== rtl/swpr_front.sv =====
// Front of the pulse rate meter: takes poll transfers, keeps the slot ring
// and window total, and queues one job per poll. Depends on swpr_pkg.
module swpr_front #(
    parameter int unsigned SLOT_COUNT = swpr_pkg::SLOT_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [47:0]      s_tdata,
    input  logic [15:0]      i_proc_period,
    input  logic [19:0]      i_slot_period,
    input  logic [15:0]      i_kalpha,
    output logic             o_push,
    output swpr_pkg::t_job   o_job,
    input  logic             i_full
);
    localparam int unsigned SW = $clog2(SLOT_COUNT);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_RD1, S_ADD, S_RD2, S_SUB, S_PUSH
    } t_state;

    t_state         r_state;
    logic [31:0]    r_mem [SLOT_COUNT];
    logic [31:0]    r_rdata;
    logic [SW-1:0]  r_addr;
    logic [SW-1:0]  r_idx;
    logic [SW-1:0]  r_filled;
    logic [31:0]    r_total;
    logic [31:0]    r_pending;
    logic [31:0]    r_padd;
    logic [31:0]    r_lpt;
    logic [31:0]    r_lst;
    logic           r_adv;
    logic           r_processed;

    logic [31:0]    now_ms;
    logic [15:0]    new_pulses;
    logic [31:0]    n_pending;
    logic           do_proc;
    logic           do_adv;
    logic [SW-1:0]  next_idx;
    logic           mem_we;
    logic [31:0]    mem_wdata;
    logic [SW+19:0] slot_ms;

    assign now_ms     = s_tdata[31:0];
    assign new_pulses = s_tdata[47:32];
    assign n_pending  = r_pending + 32'(new_pulses);
    assign do_proc    = (now_ms - r_lpt) >= 32'(i_proc_period);
    assign do_adv     = (now_ms - r_lst) >= 32'(i_slot_period);
    assign next_idx   = (r_idx == SW'(SLOT_COUNT - 1)) ? '0 : r_idx + 1'b1;
    assign s_tready   = (r_state == S_IDLE);

    assign mem_we    = (r_state == S_CLR) || (r_state == S_ADD) || (r_state == S_SUB);
    assign mem_wdata = (r_state == S_ADD) ? r_rdata + r_padd : '0;

    assign slot_ms          = r_filled * i_slot_period;
    assign o_push           = (r_state == S_PUSH) && !i_full;
    assign o_job.processed  = r_processed;
    assign o_job.count      = r_total;
    assign o_job.itime      = 32'(slot_ms) + r_lpt - r_lst;
    assign o_job.kalpha     = i_kalpha;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_idx       <= '0;
            r_filled    <= '0;
            r_total     <= '0;
            r_pending   <= '0;
            r_lpt       <= '0;
            r_lst       <= '0;
            r_adv       <= 1'b0;
            r_processed <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    // The ring is zeroed one slot per cycle after reset.
                    if (r_addr == SW'(SLOT_COUNT - 1)) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_processed <= do_proc;
                        if (do_proc) begin
                            r_padd    <= n_pending;
                            r_pending <= '0;
                            r_lpt     <= now_ms;
                            r_addr    <= r_idx;
                            r_adv     <= do_adv;
                            if (do_adv) begin
                                r_lst <= r_lst + 32'(i_slot_period);
                                r_idx <= next_idx;
                                if (r_filled != SW'(SLOT_COUNT - 1)) begin
                                    r_filled <= r_filled + 1'b1;
                                end
                            end
                            r_state <= S_RD1;
                        end else begin
                            r_pending <= n_pending;
                            r_state   <= S_PUSH;
                        end
                    end
                end
                S_RD1: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_total <= r_total + r_padd;
                    if (r_adv) begin
                        r_addr  <= r_idx;
                        r_state <= S_RD2;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_RD2: begin
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    // The slot that is entered leaves the window.
                    r_total <= r_total - r_rdata;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/swpr_back.sv =====
// Back of the pulse rate meter: square root, three divisions and the
// registered result stage. Depends on swpr_pkg.
module swpr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  swpr_pkg::t_job   i_job,
    output logic             o_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [239:0]     m_tdata
);
    typedef enum logic [2:0] {
        B_IDLE, B_MUL, B_SQRT, B_MUL2, B_DIV, B_OUT
    } t_state;

    t_state          r_state;
    swpr_pkg::t_job  r_job;
    logic [55:0]     r_p;
    logic [47:0]     r_d;
    logic [55:0]     r_e;
    logic [63:0]     r_x;
    logic [33:0]     r_sqrem;
    logic [31:0]     r_root;
    logic [4:0]      r_scnt;
    logic [71:0]     r_num;
    logic [47:0]     r_den;
    logic [47:0]     r_rem;
    logic [71:0]     r_q;
    logic [6:0]      r_dcnt;
    logic [1:0]      r_sel;
    logic [55:0]     r_cpm;
    logic [55:0]     r_dose;
    logic            r_ovalid;
    logic [239:0]    r_odata;

    logic [34:0]     sq_sh;
    logic [34:0]     sq_trial;
    logic            sq_ge;
    logic [48:0]     dv_sh;
    logic            dv_ge;
    logic [71:0]     q_next;
    logic [55:0]     q_sat;
    logic            no_time;
    logic            no_dose;

    assign sq_sh    = {r_sqrem[32:0], r_x[63:62]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    assign dv_sh  = {r_rem, r_num[71]};
    assign dv_ge  = dv_sh >= {1'b0, r_den};
    assign q_next = {r_q[70:0], dv_ge};
    assign q_sat  = (|q_next[71:56]) ? swpr_pkg::MAX56 : q_next[55:0];

    assign no_time = (r_job.itime == '0);
    assign no_dose = no_time || (r_job.kalpha == '0);

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (m_tready && (r_state != B_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_x     <= {i_job.count, 32'd0};
                        r_sqrem <= '0;
                        r_root  <= '0;
                        r_scnt  <= '0;
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_p     <= r_job.count * swpr_pkg::CPM_SCALE;
                    r_d     <= r_job.itime * r_job.kalpha;
                    r_state <= B_SQRT;
                end
                B_SQRT: begin
                    // Two radicand bits per cycle, one root bit per cycle.
                    r_x <= {r_x[61:0], 2'b00};
                    if (sq_ge) begin
                        r_sqrem <= 34'(sq_sh - sq_trial);
                        r_root  <= {r_root[30:0], 1'b1};
                    end else begin
                        r_sqrem <= 34'(sq_sh);
                        r_root  <= {r_root[30:0], 1'b0};
                    end
                    r_scnt <= r_scnt + 1'b1;
                    if (r_scnt == 5'd31) begin
                        r_state <= B_MUL2;
                    end
                end
                B_MUL2: begin
                    r_e     <= r_root * swpr_pkg::CPM_SCALE;
                    r_num   <= {16'd0, r_p};
                    r_den   <= {16'd0, r_job.itime};
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_dcnt  <= '0;
                    r_sel   <= 2'd0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    if (r_dcnt == 7'd71) begin
                        r_rem  <= '0;
                        r_q    <= '0;
                        r_dcnt <= '0;
                        r_den  <= r_d;
                        r_sel  <= r_sel + 1'b1;
                        if (r_sel == 2'd0) begin
                            r_cpm <= q_sat;
                            r_num <= {r_p, 16'd0};
                        end else if (r_sel == 2'd1) begin
                            r_dose <= q_sat;
                            r_num  <= {16'd0, r_e};
                        end else begin
                            r_num   <= {16'd0, q_sat};
                            r_state <= B_OUT;
                        end
                    end else begin
                        r_num  <= {r_num[70:0], 1'b0};
                        r_rem  <= dv_ge ? 48'(dv_sh - {1'b0, r_den}) : 48'(dv_sh);
                        r_q    <= q_next;
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                B_OUT: begin
                    // The finished error quotient waits in r_num.
                    if (!r_ovalid || m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {7'd0,
                                     no_dose ? 56'd0 : r_num[55:0],
                                     no_dose ? 56'd0 : r_dose,
                                     no_time ? 56'd0 : r_cpm,
                                     r_job.itime,
                                     r_job.count,
                                     r_job.processed};
                        r_state  <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sliding_window_pulse_rate.sv =====
// Sliding window pulse rate meter, top level with the register file.
// Depends on swpr_pkg, swpr_front, swpr_fifo and swpr_back.
//
// A poll transfer on the s_ channel carries the millisecond time and the new
// pulse count; every poll yields exactly one result transfer on the m_
// channel with the window count, integration time, count rate, dose rate and
// dose error. The front reads, updates and clears the slot ring through one
// memory port, then hands the job of a poll to a two-entry queue, and takes
// no new poll until that job is queued. The back takes one job at a time:
// 32 square root steps and three 72-step restoring divisions on one shared
// divider; it takes the next job only once the result has been loaded into
// its output register. After reset the slot ring is cleared in S_CLR, during
// which s_tready stays low; register writes are taken at any time.
// A stalled receiver holds the result register, then fills the queue, and
// finally drops s_tready. Registers are written through the APB port at
// 0x0 (process period), 0x4 (slot period) and 0x8 (kalpha); the user must
// write them only while idle, and the block itself does not enforce this.
module sliding_window_pulse_rate #(
    parameter int unsigned SLOT_COUNT = swpr_pkg::SLOT_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,   // now_ms[31:0], new_pulses[47:32]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [239:0]  m_tdata,   // processed[0], window_count[32:1],
                                     // integration_ms[64:33], cpm_q8[120:65],
                                     // dose_rate_q16[176:121],
                                     // dose_error_q16[232:177]
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    logic [15:0]     r_proc_period;
    logic [19:0]     r_slot_period;
    logic [15:0]     r_kalpha;

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    swpr_pkg::t_job  job_in;
    swpr_pkg::t_job  job_out;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_period <= swpr_pkg::PROC_PERIOD_RST;
            r_slot_period <= swpr_pkg::SLOT_PERIOD_RST;
            r_kalpha      <= swpr_pkg::KALPHA_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                swpr_pkg::REG_PROC_PERIOD: r_proc_period <= pwdata[15:0];
                swpr_pkg::REG_SLOT_PERIOD: r_slot_period <= pwdata[19:0];
                swpr_pkg::REG_KALPHA:      r_kalpha      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            swpr_pkg::REG_PROC_PERIOD: prdata = {16'd0, r_proc_period};
            swpr_pkg::REG_SLOT_PERIOD: prdata = {12'd0, r_slot_period};
            swpr_pkg::REG_KALPHA:      prdata = {16'd0, r_kalpha};
            default:                   prdata = '0;
        endcase
    end

    swpr_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .i_proc_period (r_proc_period),
        .i_slot_period (r_slot_period),
        .i_kalpha      (r_kalpha),
        .o_push        (push),
        .o_job         (job_in),
        .i_full        (full)
    );

    swpr_fifo #(
        .DEPTH (swpr_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_full  (full),
        .o_empty (empty)
    );

    swpr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_job    (job_out),
        .o_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("job queue read while empty");

    a_zero_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[64:33] == 32'd0) |->
        (m_tdata[120:65] == 56'd0 && m_tdata[176:121] == 56'd0))
        else $error("nonzero rate with zero integration time");

endmodule

// ===== tb/tb_sliding_window_pulse_rate.sv =====
// Self-checking testbench for sliding_window_pulse_rate: polls in, one rate result out.
// Depends on swpr_pkg and the RTL top; a rate predictor or a typed row checks every result.
`timescale 1ns / 1ps

module tb_sliding_window_pulse_rate;

    localparam int unsigned RING       = swpr_pkg::SLOT_COUNT_DEF;
    localparam logic [1:0]  REG_UNUSED = 2'd3;
    localparam int          DRAIN_CYC  = 400;
    localparam int          CYCLE_CAP  = 2000000;

    // Listed from the highest bits down, so processed lands in bit 0.
    typedef struct packed {
        logic [55:0] err;
        logic [55:0] dose;
        logic [55:0] cpm;
        logic [31:0] itime;
        logic [31:0] count;
        logic        processed;
    } t_rate;

    typedef struct {
        logic [31:0] now;
        logic [15:0] pulses;
        bit          typed;
        t_rate       res;
    } t_poll_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [47:0]   s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [239:0]  m_tdata;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [3:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    // Predictor copy of the meter state and its registers.
    logic [15:0] proc_period;
    logic [19:0] slot_period;
    logic [15:0] kalpha;
    logic [31:0] slot_cnt [RING];
    logic [31:0] win_total;
    logic [7:0]  slot_idx;
    logic [7:0]  filled;
    logic [31:0] last_proc;
    logic [31:0] last_slot;
    logic [31:0] pending;

    t_rate       rate_q [$];
    int          errors;
    int          cycles;
    bit          no_idle;
    logic [31:0] cur_ms;

    sliding_window_pulse_rate u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        cycles = 0;
        forever begin
            #1 i_clk = ~i_clk;
            if (i_clk) begin
                cycles++;
                if (cycles > CYCLE_CAP) begin
                    $display("tb_sliding_window_pulse_rate: FAIL");
                    $finish;
                end
            end
        end
    end

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [55:0] sat56(logic [127:0] v);
        return (v > {72'd0, swpr_pkg::MAX56}) ? swpr_pkg::MAX56 : v[55:0];
    endfunction

    function automatic t_rate predict_poll(logic [31:0] now, logic [15:0] pulses);
        t_rate       r;
        logic [7:0]  nxt;
        logic [63:0] scaled;
        logic [63:0] den;
        logic [63:0] rt;
        r = '0;
        pending = pending + pulses;
        if (now - last_proc >= {16'd0, proc_period}) begin
            slot_cnt[slot_idx] = slot_cnt[slot_idx] + pending;
            win_total = win_total + pending;
            pending = 0;
            if (now - last_slot >= {12'd0, slot_period}) begin
                last_slot = last_slot + slot_period;
                nxt = slot_idx + 8'd1;
                slot_idx = nxt;
                if (filled < 8'(RING - 1)) filled = filled + 8'd1;
                win_total = win_total - slot_cnt[nxt];
                slot_cnt[nxt] = 0;
            end
            last_proc = now;
            r.processed = 1'b1;
        end
        r.count = win_total;
        r.itime = 32'(filled) * 32'(slot_period) + last_proc - last_slot;
        if (r.itime != 0) begin
            scaled = {32'd0, win_total} * 64'(swpr_pkg::CPM_SCALE);
            r.cpm = sat56(128'(scaled / r.itime));
            if (kalpha != 0) begin
                den = 64'(r.itime) * 64'(kalpha);
                rt = root64({win_total, 32'd0});
                r.dose = sat56({48'd0, scaled, 16'd0} / 128'(den));
                r.err = sat56(128'((rt * 64'(swpr_pkg::CPM_SCALE)) / den));
            end
        end
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // Register write: setup cycle, then access cycle; pready is tied high.
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            swpr_pkg::REG_PROC_PERIOD: proc_period = val[15:0];
            swpr_pkg::REG_SLOT_PERIOD: slot_period = val[19:0];
            swpr_pkg::REG_KALPHA:      kalpha = val[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (rate_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic send_poll(logic [31:0] now, logic [15:0] pulses, bit typed, t_rate want);
        t_rate r;
        int    gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {pulses, now};
        do @(posedge i_clk); while (!s_tready);
        r = predict_poll(now, pulses);
        rate_q.push_back(typed ? want : r);
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    task automatic random_phase(int n);
        logic [31:0] d;
        logic [15:0] p;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0:       d = $urandom();
                1, 2:    d = $urandom_range(0, 32'(slot_period) * 3 + 1);
                default: d = $urandom_range(0, 32'(proc_period) * 2 + 1);
            endcase
            cur_ms = cur_ms + d;
            case ($urandom_range(0, 7))
                0:       p = 16'd0;
                1:       p = 16'hFFFF;
                2, 3:    p = $urandom();
                default: p = $urandom_range(0, 40);
            endcase
            send_poll(cur_ms, p, 1'b0, '0);
            if (k % 60 == 59) no_idle = ~no_idle;
        end
    endtask

    // Result side: random back-pressure per transfer, compare with the oldest expectation.
    initial begin
        t_rate got;
        t_rate want;
        int    gap;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = no_idle ? 0 : $urandom_range(0, 9);
            m_tready = 1'b0;
            repeat (gap) @(negedge i_clk);
            m_tready = 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            got = m_tdata[232:0];
            if (rate_q.size() == 0) begin
                report("unexpected transfer", 64'(got.count), 64'd0);
            end else begin
                want = rate_q.pop_front();
                if (got.processed != want.processed)
                    report("processed", 64'(got.processed), 64'(want.processed));
                if (got.count != want.count) report("window_count", 64'(got.count), 64'(want.count));
                if (got.itime != want.itime)
                    report("integration_ms", 64'(got.itime), 64'(want.itime));
                if (got.cpm != want.cpm) report("cpm_q8", 64'(got.cpm), 64'(want.cpm));
                if (got.dose != want.dose) report("dose_rate_q16", 64'(got.dose), 64'(want.dose));
                if (got.err != want.err) report("dose_error_q16", 64'(got.err), 64'(want.err));
            end
        end
    end

    initial begin
        t_poll_row rows [$];
        t_rate     z;
        errors = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        proc_period = swpr_pkg::PROC_PERIOD_RST;
        slot_period = swpr_pkg::SLOT_PERIOD_RST;
        kalpha = swpr_pkg::KALPHA_RST;
        for (int k = 0; k < RING; k++) slot_cnt[k] = 0;
        win_total = 0;
        slot_idx = 0;
        filled = 0;
        last_proc = 0;
        last_slot = 0;
        pending = 0;
        cur_ms = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed polls. Right after reset nothing is processed and there is no time.
        z = '0;
        rows.push_back('{32'd0, 16'd0, 1'b1, z});
        rows.push_back('{32'd100, 16'hFFFF, 1'b0, z});
        rows.push_back('{32'd160, 16'hFFFF, 1'b0, z});
        rows.push_back('{32'd6000, 16'd1, 1'b0, z});
        rows.push_back('{32'd6159, 16'd7, 1'b0, z});
        rows.push_back('{32'd12000, 16'd0, 1'b0, z});
        rows.push_back('{32'd12001, 16'd0, 1'b0, z});
        rows.push_back('{32'hFFFF_FF00, 16'd3, 1'b0, z});
        rows.push_back('{32'h0000_0050, 16'hFFFF, 1'b0, z});
        rows.push_back('{32'h0001_0000, 16'd0, 1'b0, z});
        rows.push_back('{32'h8000_0000, 16'h8000, 1'b0, z});
        rows.push_back('{32'h8000_00A0, 16'h7FFF, 1'b0, z});
        foreach (rows[k]) send_poll(rows[k].now, rows[k].pulses, rows[k].typed, rows[k].res);
        cur_ms = 32'h8000_00A0;
        random_phase(40);

        // Short periods and kalpha of one; an unknown register write must be ignored.
        wait_idle();
        reg_write(swpr_pkg::REG_PROC_PERIOD, 32'd1);
        reg_write(swpr_pkg::REG_SLOT_PERIOD, 32'd1000);
        reg_write(swpr_pkg::REG_KALPHA, 32'd1);
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        random_phase(90);

        // Large settings, upper register bits set to check the field widths.
        wait_idle();
        reg_write(swpr_pkg::REG_PROC_PERIOD, 32'hFFFF_EA60);
        reg_write(swpr_pkg::REG_SLOT_PERIOD, 32'hFFF9_27C0);
        reg_write(swpr_pkg::REG_KALPHA, 32'hFFFF_FFFF);
        random_phase(90);

        // Zero periods and zero kalpha: every poll processes and advances, ring wraps.
        wait_idle();
        reg_write(swpr_pkg::REG_PROC_PERIOD, 32'd0);
        reg_write(swpr_pkg::REG_SLOT_PERIOD, 32'd0);
        reg_write(swpr_pkg::REG_KALPHA, 32'd0);
        random_phase(280);

        wait_idle();
        if (errors == 0) begin
            $display("tb_sliding_window_pulse_rate: PASS");
        end else begin
            $display("tb_sliding_window_pulse_rate: FAIL");
        end
        $finish;
    end

endmodule
